>>> src/tbi_pkg.sv
// ---------------------------------------------------------------------------
// Triangle interpolator package
// Shared constants and the side-band record that rides through the divider.
// ---------------------------------------------------------------------------
package tbi_pkg;

   // Width of the nodal values and of the interpolated result.
   localparam int VAL_W = 32;

   // Quotient bits produced by the divider. A quotient of 2**QUO_W or more
   // can only give a clipped result, so it is flagged instead of computed.
   localparam int QUO_W = 34;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // Per-item data that travels alongside the quotient.
   typedef struct packed {
      logic signed [VAL_W-1:0] value_c;
      logic                    neg;
      logic                    ovf;
      logic                    degen;
   } tbi_side_type;

endpackage

>>> src/triangle_barycentric_interpolator.sv
// ---------------------------------------------------------------------------
// Triangle barycentric interpolator
// Weighted sum of three nodal values at a query point, rounded and clipped.
// ---------------------------------------------------------------------------
// Pipeline: 8 arithmetic stages, 34 divider stages, one output register.
// Throughput: one item per cycle while the output is not stalled.
// The divider pipeline, one quotient bit per stage, is its longest part.
// A stalled output freezes the whole pipeline. Reset clears the valid bits.
module triangle_barycentric_interpolator import tbi_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [31:0]      req_point_x,
   input  logic signed [31:0]      req_point_y,
   input  logic signed [31:0]      req_vert_a_x,
   input  logic signed [31:0]      req_vert_a_y,
   input  logic signed [31:0]      req_vert_b_x,
   input  logic signed [31:0]      req_vert_b_y,
   input  logic signed [31:0]      req_vert_c_x,
   input  logic signed [31:0]      req_vert_c_y,
   input  logic signed [VAL_W-1:0] req_value_a,
   input  logic signed [VAL_W-1:0] req_value_b,
   input  logic signed [VAL_W-1:0] req_value_c,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_interp_value,
   output logic                    rsp_degenerate,
   output logic                    rsp_saturated
);

   localparam int EW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int DW = EW + 1;            // coordinate difference
   localparam int PW = 2 * DW;            // coordinate product
   localparam int SW = PW + 1;            // area numerator or denominator
   localparam int HW = SW - 32 + 1;       // signed high part of a numerator
   localparam int LW = 66;                // 33 x 33 partial product
   localparam int MW = SW + 33;           // numerator times value difference
   localparam int NW = SW + 34;           // full weighted numerator
   localparam int XW = NW + 1;            // rounded dividend
   localparam int BW = SW + 1;            // doubled divisor
   localparam int VW = VAL_W + 1;         // value difference

   logic adv;
   logic out_valid_ff;

   // The whole pipeline moves whenever the output register can take data.
   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: coordinate and value differences.
   logic signed [EW-1:0] px, py, ax, ay, bx, by, cx, cy;
   assign px = req_point_x[EW-1:0];
   assign py = req_point_y[EW-1:0];
   assign ax = req_vert_a_x[EW-1:0];
   assign ay = req_vert_a_y[EW-1:0];
   assign bx = req_vert_b_x[EW-1:0];
   assign by = req_vert_b_y[EW-1:0];
   assign cx = req_vert_c_x[EW-1:0];
   assign cy = req_vert_c_y[EW-1:0];

   logic                    v1_ff;
   logic signed [DW-1:0]    bycy_ff, axcx_ff, cxbx_ff, aycy_ff, pxcx_ff, pycy_ff, cyay_ff;
   logic signed [VW-1:0]    dva_ff, dvb_ff;
   logic signed [VAL_W-1:0] vc1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         bycy_ff <= DW'(by) - DW'(cy);
         axcx_ff <= DW'(ax) - DW'(cx);
         cxbx_ff <= DW'(cx) - DW'(bx);
         aycy_ff <= DW'(ay) - DW'(cy);
         pxcx_ff <= DW'(px) - DW'(cx);
         pycy_ff <= DW'(py) - DW'(cy);
         cyay_ff <= DW'(cy) - DW'(ay);
         dva_ff  <= VW'(req_value_a) - VW'(req_value_c);
         dvb_ff  <= VW'(req_value_b) - VW'(req_value_c);
         vc1_ff  <= req_value_c;
      end
   end

   // Stage 2: the six cross products.
   logic                    v2_ff;
   logic signed [PW-1:0]    md0_ff, md1_ff, m10_ff, m11_ff, m20_ff, m21_ff;
   logic signed [VW-1:0]    dva2_ff, dvb2_ff;
   logic signed [VAL_W-1:0] vc2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         md0_ff  <= bycy_ff * axcx_ff;
         md1_ff  <= cxbx_ff * aycy_ff;
         m10_ff  <= bycy_ff * pxcx_ff;
         m11_ff  <= cxbx_ff * pycy_ff;
         m20_ff  <= cyay_ff * pxcx_ff;
         m21_ff  <= axcx_ff * pycy_ff;
         dva2_ff <= dva_ff;
         dvb2_ff <= dvb_ff;
         vc2_ff  <= vc1_ff;
      end
   end

   // Stage 3: denominator and the two weight numerators.
   logic                    v3_ff;
   logic signed [SW-1:0]    den3_ff, n1_ff, n2_ff;
   logic signed [VW-1:0]    dva3_ff, dvb3_ff;
   logic signed [VAL_W-1:0] vc3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         den3_ff <= SW'(md0_ff) + SW'(md1_ff);
         n1_ff   <= SW'(m10_ff) + SW'(m11_ff);
         n2_ff   <= SW'(m20_ff) + SW'(m21_ff);
         dva3_ff <= dva2_ff;
         dvb3_ff <= dvb2_ff;
         vc3_ff  <= vc2_ff;
      end
   end

   // Stage 4: numerators times value differences, split into partial products.
   logic signed [32:0]   n1_lo, n2_lo;
   logic signed [HW-2:0] n1_hi, n2_hi;
   assign n1_lo = $signed({1'b0, n1_ff[31:0]});
   assign n2_lo = $signed({1'b0, n2_ff[31:0]});
   assign n1_hi = n1_ff[SW-1:32];
   assign n2_hi = n2_ff[SW-1:32];

   logic                    v4_ff;
   logic signed [LW-1:0]    p1_lo_ff, p2_lo_ff;
   logic signed [HW+31:0]   p1_hi_ff, p2_hi_ff;
   logic signed [SW-1:0]    den4_ff;
   logic signed [VAL_W-1:0] vc4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         p1_lo_ff <= n1_lo * dva3_ff;
         p2_lo_ff <= n2_lo * dvb3_ff;
         p1_hi_ff <= n1_hi * dva3_ff;
         p2_hi_ff <= n2_hi * dvb3_ff;
         den4_ff  <= den3_ff;
         vc4_ff   <= vc3_ff;
      end
   end

   // Stage 5: recombine the partial products.
   logic                    v5_ff;
   logic signed [MW-1:0]    p1_ff, p2_ff;
   logic signed [SW-1:0]    den5_ff;
   logic signed [VAL_W-1:0] vc5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         p1_ff   <= MW'($signed({p1_hi_ff, 32'b0})) + MW'(p1_lo_ff);
         p2_ff   <= MW'($signed({p2_hi_ff, 32'b0})) + MW'(p2_lo_ff);
         den5_ff <= den4_ff;
         vc5_ff  <= vc4_ff;
      end
   end

   // Stage 6: full weighted numerator.
   logic                    v6_ff;
   logic signed [NW-1:0]    num_ff;
   logic signed [SW-1:0]    den6_ff;
   logic signed [VAL_W-1:0] vc6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
      if (adv) begin
         num_ff  <= NW'(p1_ff) + NW'(p2_ff);
         den6_ff <= den5_ff;
         vc6_ff  <= vc5_ff;
      end
   end

   // Stage 7: magnitudes, rounding offset and quotient sign.
   logic [NW-1:0] num_mag;
   logic [SW-1:0] den_mag;
   assign num_mag = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
   assign den_mag = den6_ff[SW-1] ? SW'(-den6_ff) : SW'(den6_ff);

   logic                    v7_ff;
   logic [XW-1:0]           dvd7_ff;
   logic [BW-1:0]           dvs7_ff;
   logic                    neg7_ff, degen7_ff;
   logic signed [VAL_W-1:0] vc7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= v6_ff;
      end
      if (adv) begin
         dvd7_ff   <= {num_mag, 1'b0} + XW'(den_mag);
         dvs7_ff   <= {den_mag, 1'b0};
         neg7_ff   <= num_ff[NW-1] ^ den6_ff[SW-1];
         degen7_ff <= (den6_ff == '0);
         vc7_ff    <= vc6_ff;
      end
   end

   // Stage 8: a quotient too large for the divider can only clip.
   logic         v8_ff;
   logic [XW-1:0] dvd8_ff;
   logic [BW-1:0] dvs8_ff;
   tbi_side_type side8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (adv) begin
         v8_ff <= v7_ff;
      end
      if (adv) begin
         dvd8_ff         <= dvd7_ff;
         dvs8_ff         <= dvs7_ff;
         side8_ff.value_c <= vc7_ff;
         side8_ff.neg     <= neg7_ff;
         side8_ff.ovf     <= dvd7_ff >= {dvs7_ff, {QUO_W{1'b0}}};
         side8_ff.degen   <= degen7_ff;
      end
   end

   // Rounded quotient, one bit per stage.
   logic             div_valid;
   logic [QUO_W-1:0] div_quo;
   tbi_side_type     div_side;

   tbi_div_pipe #(
      .XW(XW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v8_ff),
      .in_rem    (dvd8_ff),
      .in_div    (dvs8_ff),
      .in_side   (side8_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // Final add of the third nodal value, clipping to the value range, zero if degenerate.
   logic signed [QUO_W:0]   quo_s;
   logic signed [QUO_W+1:0] total;
   logic                    over_hi, over_lo;
   logic signed [VAL_W-1:0] value_in;
   logic                    sat_in;

   always_comb begin
      quo_s   = div_side.neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      total   = (QUO_W+2)'(div_side.value_c) + (QUO_W+2)'(quo_s);
      over_hi = total > (QUO_W+2)'(VAL_MAX);
      over_lo = total < (QUO_W+2)'(VAL_MIN);
      if (div_side.degen) begin
         value_in = '0;
         sat_in   = 1'b0;
      end else if (div_side.ovf) begin
         value_in = div_side.neg ? VAL_MIN : VAL_MAX;
         sat_in   = 1'b1;
      end else if (over_hi) begin
         value_in = VAL_MAX;
         sat_in   = 1'b1;
      end else if (over_lo) begin
         value_in = VAL_MIN;
         sat_in   = 1'b1;
      end else begin
         value_in = total[VAL_W-1:0];
         sat_in   = 1'b0;
      end
   end

   // Output register.
   logic signed [VAL_W-1:0] value_ff;
   logic                    degen_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= div_valid;
      end
      if (adv) begin
         value_ff <= value_in;
         degen_ff <= div_side.degen;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_interp_value = value_ff;
   assign rsp_degenerate   = degen_ff;
   assign rsp_saturated    = sat_ff;

   // A degenerate triangle never reports clipping.
   a_degen_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_degenerate && rsp_saturated))
      else $error("degenerate and saturated both set");

   // A degenerate triangle gives zero.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_interp_value == '0))
      else $error("degenerate result is not zero");

   // A clipped result sits on one of the range bounds.
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_interp_value == VAL_MAX || rsp_interp_value == VAL_MIN))
      else $error("saturated result is not at a bound");

   // A stalled result stays valid and unchanged until it is taken.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_interp_value)))
      else $error("stalled result changed");

endmodule

>>> src/tbi_div_pipe.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, most significant first, with stall enable.
// ---------------------------------------------------------------------------
module tbi_div_pipe import tbi_pkg::*; #(
   parameter int XW = 102
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [XW-1:0]       in_rem,
   input  logic [XW-QUO_W-1:0] in_div,
   input  tbi_side_type        in_side,
   output logic                out_valid,
   output logic [QUO_W-1:0]    out_quo,
   output tbi_side_type        out_side
);

   localparam int BW = XW - QUO_W;

   // Stage k holds the partial result after quotient bit k. The last stage
   // needs no remainder or divisor any more.
   logic               valid_ff [QUO_W];
   logic [QUO_W-1:0]   quo_ff   [QUO_W];
   tbi_side_type       side_ff  [QUO_W];
   logic [XW-1:0]      rem_ff   [QUO_W-1];
   logic [BW-1:0]      div_ff   [QUO_W-1];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int SH = QUO_W - 1 - k;
      logic             valid_prev;
      logic [XW-1:0]    rem_prev;
      logic [BW-1:0]    div_prev;
      logic [QUO_W-1:0] quo_prev;
      tbi_side_type     side_prev;
      logic [XW-1:0]    sh_div;
      logic             ge;

      // The first stage takes the input itself.
      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_rem;
         assign div_prev   = in_div;
         assign quo_prev   = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign div_prev   = div_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // Trial subtract of the divisor aligned to this quotient bit.
      assign sh_div = XW'(div_prev) << SH;
      assign ge     = rem_prev >= sh_div;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
         if (adv) begin
            quo_ff[k]  <= {quo_prev[QUO_W-2:0], ge};
            side_ff[k] <= side_prev;
         end
      end

      // Remainder and divisor move on to the next stage.
      if (k < QUO_W - 1) begin : g_carry
         logic [XW-1:0] rem_in;
         assign rem_in = ge ? (rem_prev - sh_div) : rem_prev;

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= rem_in;
               div_ff[k] <= div_prev;
            end
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

>>> verif/triangle_barycentric_interpolator_checker.sv
// ---------------------------------------------------------------------------
// Triangle interpolator checker
// Watches both channels, predicts each result in exact integer arithmetic
// and compares every result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module triangle_barycentric_interpolator_checker import tbi_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic signed [31:0]      req_point_x,
   input  logic signed [31:0]      req_point_y,
   input  logic signed [31:0]      req_vert_a_x,
   input  logic signed [31:0]      req_vert_a_y,
   input  logic signed [31:0]      req_vert_b_x,
   input  logic signed [31:0]      req_vert_b_y,
   input  logic signed [31:0]      req_vert_c_x,
   input  logic signed [31:0]      req_vert_c_y,
   input  logic signed [VAL_W-1:0] req_value_a,
   input  logic signed [VAL_W-1:0] req_value_b,
   input  logic signed [VAL_W-1:0] req_value_c,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [VAL_W-1:0] rsp_interp_value,
   input  logic                    rsp_degenerate,
   input  logic                    rsp_saturated,
   output int                      fail_count,
   output int                      pending_count,
   output int                      result_count,
   output int                      degen_count,
   output int                      clip_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EFF_CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

   typedef struct {
      logic signed [VAL_W-1:0] interp;
      logic                    degen;
      logic                    sat;
   } interp_result_type;

   interp_result_type expected_results[$];

   // Sign-extend a coordinate from its low EFF_CW bits.
   function automatic logic signed [63:0] coord_bits(logic [31:0] raw);
      logic signed [63:0] v;
      v = 64'(raw) << (64 - EFF_CW);
      return v >>> (64 - EFF_CW);
   endfunction

   // Exact barycentric interpolation with rounding half away from zero.
   function automatic interp_result_type interpolate(
      logic [31:0] px_r, logic [31:0] py_r, logic [31:0] ax_r, logic [31:0] ay_r,
      logic [31:0] bx_r, logic [31:0] by_r, logic [31:0] cx_r, logic [31:0] cy_r,
      logic signed [31:0] va, logic signed [31:0] vb, logic signed [31:0] vc);
      logic signed [63:0] px, py, ax, ay, bx, by, cx, cy;
      logic signed [199:0] den, n1, n2, num, mag_n, mag_d, quo, total;
      interp_result_type r;
      px = coord_bits(px_r); py = coord_bits(py_r);
      ax = coord_bits(ax_r); ay = coord_bits(ay_r);
      bx = coord_bits(bx_r); by = coord_bits(by_r);
      cx = coord_bits(cx_r); cy = coord_bits(cy_r);
      den = 200'(by - cy) * 200'(ax - cx) + 200'(cx - bx) * 200'(ay - cy);
      r.interp = '0;
      r.sat = 1'b0;
      r.degen = (den == 0);
      if (r.degen) return r;
      n1 = 200'(by - cy) * 200'(px - cx) + 200'(cx - bx) * 200'(py - cy);
      n2 = 200'(cy - ay) * 200'(px - cx) + 200'(ax - cx) * 200'(py - cy);
      num = n1 * 200'(64'(va) - 64'(vc)) + n2 * 200'(64'(vb) - 64'(vc));
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      quo = (2 * mag_n + mag_d) / (2 * mag_d);
      if ((num < 0) != (den < 0)) quo = -quo;
      total = 200'(vc) + quo;
      if (total > 200'(VAL_MAX)) begin
         r.interp = VAL_MAX;
         r.sat = 1'b1;
      end else if (total < 200'(VAL_MIN)) begin
         r.interp = VAL_MIN;
         r.sat = 1'b1;
      end else begin
         r.interp = total[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      result_count = 0;
      degen_count = 0;
      clip_count = 0;
   end

   // Predict on each input transfer and compare on each result transfer.
   always @(posedge clock) begin
      interp_result_type want;
      if (!reset && req_valid && req_ready) begin
         expected_results.insert(expected_results.size(), interpolate(req_point_x,
            req_point_y, req_vert_a_x, req_vert_a_y, req_vert_b_x, req_vert_b_y,
            req_vert_c_x, req_vert_c_y, req_value_a, req_value_b, req_value_c));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_interp_value, '0);
         end else begin
            want = expected_results.pop_front();
            if (want.degen) degen_count++;
            if (want.sat) clip_count++;
            if (rsp_interp_value !== want.interp)
               report_mismatch("interp_value", rsp_interp_value, want.interp);
            if (rsp_degenerate !== want.degen)
               report_mismatch("degenerate", 32'(rsp_degenerate), 32'(want.degen));
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", 32'(rsp_saturated), 32'(want.sat));
         end
      end
      pending_count = expected_results.size();
   end

endmodule

>>> verif/triangle_barycentric_interpolator_tb.sv
// ---------------------------------------------------------------------------
// Triangle interpolator testbench
// Drives directed and random triangles with random flow control and
// reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module triangle_barycentric_interpolator_tb import tbi_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 43;
   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1330;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_point_x = '0, req_point_y = '0;
   logic signed [31:0] req_vert_a_x = '0, req_vert_a_y = '0;
   logic signed [31:0] req_vert_b_x = '0, req_vert_b_y = '0;
   logic signed [31:0] req_vert_c_x = '0, req_vert_c_y = '0;
   logic signed [VAL_W-1:0] req_value_a = '0, req_value_b = '0, req_value_c = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_interp_value;
   logic rsp_degenerate, rsp_saturated;

   int fail_count, pending_count, result_count, degen_count, clip_count;
   int send_idle_pct = 9;
   int recv_idle_pct = 76;
   bit hold_off = 1'b0;
   int idle_cycles = 0;

   triangle_barycentric_interpolator dut (.*);
   triangle_barycentric_interpolator_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver readiness, redrawn at each falling edge.
   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", pending_count);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         3: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
         default: return $urandom();
      endcase
   endfunction

   // One transfer: present at the falling edge, hold until accepted.
   task automatic send(logic [31:0] px, logic [31:0] py, logic [31:0] ax,
      logic [31:0] ay, logic [31:0] bx, logic [31:0] by, logic [31:0] cx,
      logic [31:0] cy, logic [31:0] va, logic [31:0] vb, logic [31:0] vc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= px; req_point_y <= py;
      req_vert_a_x <= ax; req_vert_a_y <= ay;
      req_vert_b_x <= bx; req_vert_b_y <= by;
      req_vert_c_x <= cx; req_vert_c_y <= cy;
      req_value_a <= va; req_value_b <= vb; req_value_c <= vc;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [31:0] ax, ay, bx, by;
      ax = rand_word(); ay = rand_word(); bx = rand_word(); by = rand_word();
      case ($urandom_range(9))
         // Third vertex at 2B - A: collinear, zero area unless the 32-bit sum wraps.
         0: send(rand_word(), rand_word(), ax, ay, bx, by, 2*bx - ax, 2*by - ay,
                 rand_word(), rand_word(), rand_word());
         // Repeated vertex.
         1: send(rand_word(), rand_word(), ax, ay, ax, ay, bx, by,
                 rand_word(), rand_word(), rand_word());
         // Query point on a vertex.
         2: send(bx, by, ax, ay, bx, by, rand_word(), rand_word(),
                 rand_word(), rand_word(), rand_word());
         default: send(rand_word(), rand_word(), ax, ay, bx, by, rand_word(),
                       rand_word(), rand_word(), rand_word(), rand_word());
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: unit triangle, extremes, degenerate, outside point.
      send(32'h0000_4000, 32'h0000_4000, 0, 0, 32'h0001_0000, 0, 0,
           32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      send(0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 3);
      send(5, 5, 0, 0, 1, 1, 2, 2, 32'h7FFF_FFFF, 0, 0);
      send(32'h0010_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
           32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send(32'hFFF0_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
           32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
           32'h7FFF_FFFF, 32'h8000_0000, 0);
      send(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
           32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send(1, 1, 0, 0, 3, 0, 0, 3, 0, 1, 0);       // quotient one third
      send(1, 0, 0, 0, 2, 0, 0, 2, 0, 1, 0);       // tie rounds away from zero
      send(1, 0, 0, 0, 2, 0, 0, 2, 0, -1, 0);
      send(0, 0, 0, 0, 2, 0, 0, 2, 0, 0, 32'h7FFF_FFFF);
      send(-1, -1, 0, 0, 0, 2, 2, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
      // Pause until every result is back.
      drain();

      // Long receiver hold-off while the sender keeps offering.
      fork
         begin
            hold_off = 1'b1;
            repeat (150) @(negedge clock);
            hold_off = 1'b0;
         end
         repeat (80) send_random();
      join

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 76 : 0;
         recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 9 : 0;
         repeat (RANDOM_ITEMS / 3 - 25) send_random();
      end

      drain();
      repeat (LATENCY + 10) @(negedge clock);
      $display("Covered %0d results: %0d degenerate, %0d clipped.",
               result_count, degen_count, clip_count);
      $display("Flow control ran skewed both ways, free, and with a long stall.");
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

>>> triangle_barycentric_interpolator.f
src/tbi_pkg.sv
src/tbi_div_pipe.sv
src/triangle_barycentric_interpolator.sv
verif/triangle_barycentric_interpolator_checker.sv
verif/triangle_barycentric_interpolator_tb.sv
